// ===== design/deadzone_soft_saturated_position_drive_defines.svh =====
// Assertion macros for the soft-saturated position drive.
`ifndef DEADZONE_SOFT_SATURATED_POSITION_DRIVE_DEFINES_SVH
`define DEADZONE_SOFT_SATURATED_POSITION_DRIVE_DEFINES_SVH
`ifndef SYNTHESIS
// Implication in the same cycle, clocked on clk, held off during reset.
`define DZPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication after a fixed number of cycles.
`define DZPD_ASSERT_DLY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");
`else
`define DZPD_ASSERT_IMP(lbl, ante, cons)
`define DZPD_ASSERT_DLY(lbl, ante, n, cons)
`endif
`endif

// ===== design/dzpd_pkg.sv =====
// Shared types and constants of the soft-saturated position drive.
`default_nettype none
package dzpd_pkg;

	localparam int TANH_DEPTH_DEF = 256;
	localparam int DIV_STEPS      = 19;
	localparam int PIPE_LATENCY   = 32;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef enum logic [2:0] {
		REG_TARGET   = 3'd0,
		REG_GAIN     = 3'd1,
		REG_LIMIT    = 3'd2,
		REG_DEADZONE = 3'd3,
		REG_AXIS_X   = 3'd4,
		REG_AXIS_Y   = 3'd5,
		REG_AXIS_Z   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        neg;
		logic        in_dz;
		logic        sat;
		logic [31:0] frc_unl;
	} side_t;

endpackage
`default_nettype wire

// ===== design/deadzone_soft_saturated_position_drive.sv =====
// Top level of the soft-saturated position drive with error deadzone.
// Usage:
//   Configure through wr_en / wr_index / wr_data while no item is in flight;
//   index 0 target, 1 gain, 2 force limit, 3 deadzone, 4..6 axis x, y, z.
//   Present the two body positions with start high; busy is always low, so
//   an item is taken at every edge that sees start, one per clock cycle.
//   Each item gives one result: done is high for one cycle with drive_force
//   and stiffness. The receiver cannot stall the block; results must
//   be taken as they appear.
//   The 32-stage pipeline holds: projection, deadzone, a gain
//   multiply split into two partial products, a 19-stage restoring divider
//   for the tanh argument (one quotient bit per stage), table lookup with
//   interpolation, and the output multiplies.
//   Reset clears all valid bits and loads the register reset values; items
//   in flight are dropped. No clearing pass is needed.
`default_nettype none
`include "deadzone_soft_saturated_position_drive_defines.svh"
module deadzone_soft_saturated_position_drive
	import dzpd_pkg::*;
#(
	parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] first_x,
	input  wire logic signed [31:0] first_y,
	input  wire logic signed [31:0] first_z,
	input  wire logic signed [31:0] second_x,
	input  wire logic signed [31:0] second_y,
	input  wire logic signed [31:0] second_z,
	input  wire logic               wr_en,
	input  wire logic [2:0]         wr_index,
	input  wire logic [31:0]        wr_data,
	output logic                    done,
	output logic signed [31:0]      drive_force,
	output logic [31:0]             stiffness
);

	localparam int IW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int PW = DIV_STEPS + IW;
	localparam logic [IW-1:0] DEPTH_C = IW'(TANH_TABLE_DEPTH);

	// shift-and-subtract quotient of two non-negative values, table build only
	function automatic longint cdiv(input longint n, input longint d);
		longint qv, rv;
		qv = 0;
		rv = 0;
		for (int bp = 62; bp >= 0; bp--) begin
			rv = (rv << 1) | ((n >>> bp) & longint'(1));
			qv = qv << 1;
			if (rv >= d) begin
				rv = rv - d;
				qv = qv | longint'(1);
			end
		end
		return qv;
	endfunction

	// tanh(8*i/D) in Q1.16, built at elaboration
	function automatic logic [16:0] tanh_entry(input int i);
		longint one, z, term, sum, q, num, den;
		int k;
		one  = longint'(1) << 30;
		z    = cdiv(longint'(i) << 30, longint'(TANH_TABLE_DEPTH));
		term = one;
		sum  = one;
		for (k = 1; k <= 20; k++) begin
			term = cdiv((term * z) >>> 30, longint'(k));
			sum  = k[0] ? sum - term : sum + term;
		end
		q = (sum < 0) ? 0 : ((sum > one) ? one : sum);
		for (k = 0; k < 4; k++) begin
			q = (q * q) >>> 30;
		end
		num = (one - q) << 16;
		den = one + q;
		return 17'(cdiv(num + (den >>> 1), den));
	endfunction

	logic [16:0] tanh_tab [TANH_TABLE_DEPTH+1];
	for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [16:0] Ent = tanh_entry(g);
		assign tanh_tab[g] = Ent;
	end

	// configuration registers
	logic signed [31:0] target_q;
	logic [31:0]        gain_q;
	logic [30:0]        lim_q;
	logic [30:0]        dzw_q;
	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			gain_q   <= '0;
			lim_q    <= '0;
			dzw_q    <= '0;
			axis_x_q <= 16'sd16384;
			axis_y_q <= '0;
			axis_z_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TARGET:   target_q <= wr_data;
				REG_GAIN:     gain_q   <= wr_data;
				REG_LIMIT:    lim_q    <= wr_data[30:0];
				REG_DEADZONE: dzw_q    <= wr_data[30:0];
				REG_AXIS_X:   axis_x_q <= wr_data[15:0];
				REG_AXIS_Y:   axis_y_q <= wr_data[15:0];
				REG_AXIS_Z:   axis_z_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic dv_vld_s [DIV_STEPS+1];   // index k is stage 8+k
	logic vld_s28, vld_s29, vld_s30, vld_s31, vld_s32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
			vld_s30 <= 1'b0;
			vld_s31 <= 1'b0;
			vld_s32 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s1      <= start && !busy;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			dv_vld_s[0] <= vld_s7;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
			vld_s28 <= dv_vld_s[DIV_STEPS];
			vld_s29 <= vld_s28;
			vld_s30 <= vld_s29;
			vld_s31 <= vld_s30;
			vld_s32 <= vld_s31;
		end
	end

	// stage 1: separations
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		dx_s1 <= 33'(second_x) - 33'(first_x);
		dy_s1 <= 33'(second_y) - 33'(first_y);
		dz_s1 <= 33'(second_z) - 33'(first_z);
	end

	// stage 2: axis products
	logic signed [48:0] px_s2, py_s2, pz_s2;
	always_ff @(posedge clk) begin
		px_s2 <= dx_s1 * axis_x_q;
		py_s2 <= dy_s1 * axis_y_q;
		pz_s2 <= dz_s1 * axis_z_q;
	end

	// stage 3: projection, floor to Q16.16
	logic signed [50:0] sum_w;
	logic signed [36:0] proj_s3;
	assign sum_w = 51'(px_s2) + 51'(py_s2) + 51'(pz_s2);
	always_ff @(posedge clk) begin
		proj_s3 <= sum_w[50:14];
	end

	// stage 4: error
	logic signed [37:0] err_s4;
	always_ff @(posedge clk) begin
		err_s4 <= 38'(target_q) - 38'(proj_s3);
	end

	// stage 5: deadzone, magnitude and sign
	logic signed [37:0] dzw_ext;
	logic               over_w, under_w;
	logic [37:0]        abs_w;
	logic [37:0]        abs_s5;
	side_t              side_s5;
	assign dzw_ext = {7'b0, dzw_q};
	assign over_w  = err_s4 > dzw_ext;
	assign under_w = err_s4 < -dzw_ext;
	always_comb begin
		priority if (over_w) begin
			abs_w = 38'(err_s4 - dzw_ext);
		end else if (under_w) begin
			abs_w = 38'(-err_s4 - dzw_ext);
		end else begin
			abs_w = '0;
		end
	end
	always_ff @(posedge clk) begin
		abs_s5          <= abs_w;
		side_s5.neg     <= under_w;
		side_s5.in_dz   <= !over_w && !under_w;
		side_s5.sat     <= 1'b0;
		side_s5.frc_unl <= '0;
	end

	// stage 6: gain partial products
	logic [63:0] plo_s6;
	logic [37:0] phi_s6;
	side_t       side_s6;
	always_ff @(posedge clk) begin
		plo_s6  <= 64'(abs_s5[31:0]) * 64'(gain_q);
		phi_s6  <= 38'(abs_s5[37:32]) * 38'(gain_q);
		side_s6 <= side_s5;
	end

	// stage 7: raw force magnitude, capped at 2^40
	localparam logic [40:0] FORCE_CAP = 41'h100_0000_0000;
	logic [69:0] full_w;
	logic [53:0] shr_w;
	logic [40:0] mag_s7;
	side_t       side_s7;
	assign full_w = {phi_s6, 32'b0} + 70'(plo_s6);
	assign shr_w  = full_w[69:16];
	always_ff @(posedge clk) begin
		mag_s7  <= (shr_w > 54'(FORCE_CAP)) ? FORCE_CAP : shr_w[40:0];
		side_s7 <= side_s6;
	end

	// stage 8: unlimited force, tanh saturation check, divider setup
	logic [30:0]        dv_rem_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_num_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_quo_s [DIV_STEPS+1];
	side_t              dv_side_s [DIV_STEPS+1];
	logic [31:0]        unl_w;
	always_comb begin
		if (side_s7.neg) begin
			unl_w = (mag_s7 >= 41'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag_s7[31:0];
		end else begin
			unl_w = (mag_s7 > 41'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_s7[31:0];
		end
	end
	always_ff @(posedge clk) begin
		dv_rem_s[0]          <= mag_s7[33:3];
		dv_num_s[0]          <= {mag_s7[2:0], 16'b0};
		dv_quo_s[0]          <= '0;
		dv_side_s[0].neg     <= side_s7.neg;
		dv_side_s[0].in_dz   <= side_s7.in_dz;
		dv_side_s[0].sat     <= mag_s7 >= {7'b0, lim_q, 3'b0};
		dv_side_s[0].frc_unl <= unl_w;
	end

	// stages 9..27: one quotient bit per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [31:0] part_w;
		logic        ge_w;
		assign part_w = {dv_rem_s[k-1], dv_num_s[k-1][DIV_STEPS-1]};
		assign ge_w   = part_w >= {1'b0, lim_q};
		always_ff @(posedge clk) begin
			dv_rem_s[k]  <= ge_w ? 31'(part_w - {1'b0, lim_q}) : part_w[30:0];
			dv_num_s[k]  <= {dv_num_s[k-1][DIV_STEPS-2:0], 1'b0};
			dv_quo_s[k]  <= {dv_quo_s[k-1][DIV_STEPS-2:0], ge_w};
			dv_side_s[k] <= dv_side_s[k-1];
		end
	end

	// stage 28: table position
	logic [PW-1:0] pos_w;
	logic [IW-1:0] idx_s28;
	logic [15:0]   frac_s28;
	side_t         side_s28;
	assign pos_w = PW'(dv_quo_s[DIV_STEPS]) * PW'(DEPTH_C);
	always_ff @(posedge clk) begin
		idx_s28  <= pos_w[PW-1:DIV_STEPS];
		frac_s28 <= pos_w[18:3];
		side_s28 <= dv_side_s[DIV_STEPS];
	end

	// stage 29: table read
	logic [16:0] ta_s29, tb_s29;
	logic [15:0] frac_s29;
	side_t       side_s29;
	always_ff @(posedge clk) begin
		ta_s29   <= tanh_tab[idx_s28];
		tb_s29   <= tanh_tab[IW'(idx_s28 + 1'b1)];
		frac_s29 <= frac_s28;
		side_s29 <= side_s28;
	end

	// stage 30: interpolate
	logic [32:0] step_w;
	logic [16:0] t_s30;
	side_t       side_s30;
	assign step_w = 33'(17'(tb_s29 - ta_s29)) * 33'(frac_s29);
	always_ff @(posedge clk) begin
		priority if (side_s29.sat) begin
			t_s30 <= ONE_Q16;
		end else if (tb_s29 < ta_s29) begin
			t_s30 <= ta_s29;
		end else begin
			t_s30 <= ta_s29 + step_w[32:16];
		end
		side_s30 <= side_s29;
	end

	// stage 31: limited force and sech^2
	logic [47:0] fm_w;
	logic [33:0] tt_w;
	logic [30:0] fm_s31;
	logic [16:0] sech2_s31;
	side_t       side_s31;
	assign fm_w = 48'(lim_q) * 48'(t_s30);
	assign tt_w = 34'(t_s30) * 34'(t_s30);
	always_ff @(posedge clk) begin
		fm_s31    <= fm_w[46:16];
		sech2_s31 <= ONE_Q16 - tt_w[32:16];
		side_s31  <= side_s30;
	end

	// stage 32: stiffness and output select
	logic [48:0] sp_w;
	logic signed [31:0] force_s32;
	logic [31:0]        stiff_s32;
	assign sp_w = 49'(gain_q) * 49'(sech2_s31);
	always_ff @(posedge clk) begin
		if (lim_q == '0) begin
			force_s32 <= side_s31.frc_unl;
			stiff_s32 <= gain_q;
		end else begin
			force_s32 <= side_s31.neg ? 32'd0 - {1'b0, fm_s31} : {1'b0, fm_s31};
			stiff_s32 <= (gain_q == '0 || side_s31.in_dz) ? '0 : sp_w[47:16];
		end
	end

	assign done        = vld_s32;
	assign drive_force = force_s32;
	assign stiffness   = stiff_s32;

	`DZPD_ASSERT_DLY(a_latency, start, PIPE_LATENCY, done)
	`DZPD_ASSERT_DLY(a_no_spurious, !start, PIPE_LATENCY, !done)
	`DZPD_ASSERT_IMP(a_tanh_range, vld_s30, t_s30 <= ONE_Q16)
	`DZPD_ASSERT_IMP(a_dz_sign, vld_s5, !(side_s5.in_dz && side_s5.neg) && (!side_s5.in_dz || abs_s5 == '0))

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the soft-saturated position drive with deadzone.
`timescale 1ns / 1ps
module tb
	import dzpd_pkg::*;
();

	localparam int LUT_DEPTH = 256;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] MAG_CAP = 64'd1 << 40;

	typedef struct {
		logic signed [31:0] drive;
		logic [31:0]        stiff;
	} drive_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [31:0] wr_data = '0;
	logic done;
	logic signed [31:0] drive_force;
	logic [31:0] stiffness;

	// shadow copy of the configuration registers
	logic signed [31:0] cfg_target;
	logic [31:0]        cfg_gain;
	logic [30:0]        cfg_limit;
	logic [30:0]        cfg_deadzone;
	logic signed [15:0] cfg_ax, cfg_ay, cfg_az;

	int unsigned tanh_lut [0:LUT_DEPTH];
	drive_res_t  pending_results [$];
	int          fail_count = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          limited_items = 0;
	longint      cycle_count = 0;
	bit          calm = 1'b0;

	deadzone_soft_saturated_position_drive u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .drive_force(drive_force), .stiffness(stiffness)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// tanh(8i/D) in Q1.16 via exp(-16z) from a truncated Taylor series
	function automatic void build_tanh_lut();
		longint one;
		longint z, term, sum, q;
		logic [63:0] num, den;
		one = longint'(1) << 30;
		for (int i = 0; i <= LUT_DEPTH; i++) begin
			z = (longint'(i) << 30) / LUT_DEPTH;
			term = one;
			sum = one;
			for (int k = 1; k <= 20; k++) begin
				term = ((term * z) >>> 30) / k;
				sum = (k % 2 == 1) ? sum - term : sum + term;
			end
			q = (sum < 0) ? 0 : ((sum > one) ? one : sum);
			for (int k = 0; k < 4; k++)
				q = (q * q) >>> 30;
			num = 64'(one - q) << 16;
			den = 64'(one + q);
			tanh_lut[i] = 32'((num + den / 2) / den);
		end
	endfunction

	function automatic logic [31:0] tanh_interp(logic [63:0] s);
		logic [63:0] pos, idx, frac;
		int unsigned a, b;
		if (s >= (64'd8 << 16))
			return 32'd65536;
		pos = (s * LUT_DEPTH) >> 3;
		idx = pos >> 16;
		frac = pos & 64'hFFFF;
		if (idx >= LUT_DEPTH)
			return tanh_lut[LUT_DEPTH];
		a = tanh_lut[idx];
		b = tanh_lut[idx + 1];
		if (b < a)
			return a;
		return a + 32'((64'(b - a) * frac) >> 16);
	endfunction

	function automatic drive_res_t predict_drive(logic signed [31:0] fx, logic signed [31:0] fy,
			logic signed [31:0] fz, logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz);
		longint dx, dy, dz, proj, err, e, dzw, frc;
		logic [63:0] a, hi, lo, g, mag, lim, s, fm, t, sech2, stiff;
		logic neg;
		drive_res_t r;
		dx = longint'(sx) - longint'(fx);
		dy = longint'(sy) - longint'(fy);
		dz = longint'(sz) - longint'(fz);
		proj = dx * longint'(cfg_ax) + dy * longint'(cfg_ay) + dz * longint'(cfg_az);
		proj = proj >>> 14;
		err = longint'(cfg_target) - proj;
		dzw = longint'({33'd0, cfg_deadzone});
		if (err > dzw)
			e = err - dzw;
		else if (err < -dzw)
			e = err + dzw;
		else
			e = 0;
		neg = e < 0;
		a = neg ? 64'(-e) : 64'(e);
		g = {32'd0, cfg_gain};
		hi = a >> 16;
		lo = a & 64'hFFFF;
		if (hi != 0 && g > MAG_CAP / hi) begin
			mag = MAG_CAP;
		end else begin
			mag = hi * g + ((lo * g) >> 16);
			if (mag > MAG_CAP)
				mag = MAG_CAP;
		end
		lim = {33'd0, cfg_limit};
		if (lim == 0) begin
			frc = neg ? -longint'(mag) : longint'(mag);
			stiff = g;
		end else begin
			s = (mag << 16) / lim;
			t = {32'd0, tanh_interp(s)};
			fm = (lim * t) >> 16;
			frc = neg ? -longint'(fm) : longint'(fm);
			if (g == 0 || (err <= dzw && err >= -dzw)) begin
				stiff = 0;
			end else begin
				sech2 = 64'd65536 - ((t * t) >> 16);
				stiff = (g * sech2) >> 16;
			end
		end
		if (frc > 64'sd2147483647)
			frc = 64'sd2147483647;
		if (frc < -64'sd2147483648)
			frc = -64'sd2147483648;
		r.drive = frc[31:0];
		r.stiff = (stiff > 64'hFFFFFFFF) ? 32'hFFFFFFFF : stiff[31:0];
		return r;
	endfunction

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		drive_res_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: drive_force %0d stiffness %0d",
					drive_force, stiffness);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (drive_force !== exp_r.drive) begin
					$error("drive_force: expected %0d, got %0d", exp_r.drive, drive_force);
					fail_count++;
				end
				if (stiffness !== exp_r.stiff) begin
					$error("stiffness: expected %0d, got %0d", exp_r.stiff, stiffness);
					fail_count++;
				end
			end
		end
	end

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// one transfer; start stays high on return so back-to-back items keep going
	task automatic send_item(logic signed [31:0] fx, logic signed [31:0] fy,
			logic signed [31:0] fz, logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz);
		if (!calm && $urandom_range(99) < 16)
			idle_cycles(1);
		start <= 1'b1;
		first_x <= fx; first_y <= fy; first_z <= fz;
		second_x <= sx; second_y <= sy; second_z <= sz;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_drive(fx, fy, fz, sx, sy, sz));
		items_sent++;
		if (cfg_limit != 0)
			limited_items++;
	endtask

	// let the pipeline empty before touching the registers
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_TARGET:   cfg_target = value;
			REG_GAIN:     cfg_gain = value;
			REG_LIMIT:    cfg_limit = value[30:0];
			REG_DEADZONE: cfg_deadzone = value[30:0];
			REG_AXIS_X:   cfg_ax = value[15:0];
			REG_AXIS_Y:   cfg_ay = value[15:0];
			REG_AXIS_Z:   cfg_az = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_drive(logic signed [31:0] tgt, logic [31:0] gain, logic [30:0] lim,
			logic [30:0] dzw, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		drain();
		write_reg(REG_TARGET, tgt);
		write_reg(REG_GAIN, gain);
		write_reg(REG_LIMIT, {1'b0, lim});
		write_reg(REG_DEADZONE, {1'b0, dzw});
		write_reg(REG_AXIS_X, {{16{ax[15]}}, ax});
		write_reg(REG_AXIS_Y, {{16{ay[15]}}, ay});
		write_reg(REG_AXIS_Z, {{16{az[15]}}, az});
	endtask

	function automatic logic signed [31:0] rand_coord(bit near);
		if (near)
			return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
		return $urandom;
	endfunction

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(3))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_item(0, 0, 0, 0, 0, 0);
		send_item(32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0, 0);
		send_item(32'sh80000000, 5, 6, 32'sh7FFFFFFF, 7, 8);
	endtask

	task automatic test_unlimited();
		set_drive(32'sh0001_0000, 32'h0002_0000, 0, 0, 16'sd16384, 16'sd0, 16'sd0);
		send_item(0, 0, 0, 32'sh0001_0000, 0, 0);
		send_item(0, 0, 0, 32'sh0003_8000, 0, 0);
		send_item(0, 0, 0, 32'sh80000000, 0, 0);
		set_drive(32'sh7FFFFFFF, 32'hFFFFFFFF, 0, 0, -16'sd16384, 16'sd16384, -16'sd16384);
		send_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
		send_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
		send_item(0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_deadzone_and_limit();
		// deadzone edges, zero error, gain of zero, tanh saturation
		set_drive(0, 32'h0001_0000, 31'h0004_0000, 31'h0001_0000, 16'sd16384, 16'sd0, 16'sd0);
		send_item(0, 0, 0, 0, 0, 0);
		send_item(0, 0, 0, 32'sh0001_0000, 0, 0);
		send_item(0, 0, 0, -32'sh0001_0001, 0, 0);
		send_item(0, 0, 0, 32'sh0003_0000, 0, 0);
		send_item(0, 0, 0, -32'sh0040_0000, 0, 0);
		send_item(0, 0, 0, 32'sh7FFFFFFF, 0, 0);
		set_drive(-32'sh0000_8000, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'sd0, 16'sd0, 16'sd0);
		send_item(1, 2, 3, 4, 5, 6);
		set_drive(32'sh0000_1000, 32'hFFFFFFFF, 31'd1, 31'd0, 16'sd1, -16'sd1, 16'sd100);
		send_item(0, 0, 0, 0, 0, 0);
		send_item(32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0);
	endtask

	task automatic test_random_phases();
		logic [31:0] gain;
		logic [30:0] lim;
		bit near;
		for (int ph = 0; ph < 14; ph++) begin
			case ($urandom_range(3))
				0: gain = 32'hFFFFFFFF;
				1: gain = 0;
				default: gain = $urandom_range(0, 32'h0010_0000);
			endcase
			case ($urandom_range(3))
				0: lim = 0;
				1: lim = 31'h7FFFFFFF;
				default: lim = 31'($urandom_range(1, 32'h0040_0000));
			endcase
			set_drive((ph % 3 == 0) ? $urandom : rand_coord(1'b1), gain, lim,
				(ph % 4 == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0002_0000)),
				rand_axis(), rand_axis(), rand_axis());
			for (int n = 0; n < 100; n++) begin
				// a long burst without gaps in every third phase
				calm = (ph % 3 == 1) && n < 60;
				near = $urandom_range(9) < 7;
				send_item(rand_coord(near), rand_coord(near), rand_coord(near),
					rand_coord(near), rand_coord(near), rand_coord(near));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		build_tanh_lut();
		cfg_target = 0; cfg_gain = 0; cfg_limit = 0; cfg_deadzone = 0;
		cfg_ax = 16'sd16384; cfg_ay = 0; cfg_az = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_unlimited();
		test_deadzone_and_limit();
		test_random_phases();
		drain();
		$display("Sent %0d positions (%0d under a force limit), checked %0d results.",
			items_sent, limited_items, results_seen);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/dzpd_pkg.sv
design/deadzone_soft_saturated_position_drive.sv
tb/sv/tb.sv
